[hdl/iee_pkg.sv]
// Package for the infix expression evaluator: word types, sizes, codes.
// Used by iee_div and infix_expression_evaluator; depends on nothing.
`default_nettype none
package iee_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int OP_ENTRIES  = 4;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ENT_W       = (OP_ENTRIES > 1) ? $clog2(OP_ENTRIES) : 1;
  localparam int IDX_W       = $clog2(OP_ENTRIES + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int FRAC_W      = 16;
  localparam int DIV_W       = 32 + FRAC_W;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  localparam logic [IDX_W-1:0] LB_MARK = IDX_W'(OP_ENTRIES);

  localparam logic [1:0] ACT_NUMBER = 2'd0;
  localparam logic [1:0] ACT_SYMBOL = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;

  localparam logic [2:0] OPC_ADD = 3'd0;
  localparam logic [2:0] OPC_SUB = 3'd1;
  localparam logic [2:0] OPC_MUL = 3'd2;
  localparam logic [2:0] OPC_DIV = 3'd3;

  localparam logic [7:0] CH_LB = 8'h28;
  localparam logic [7:0] CH_RB = 8'h29;

  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_NO_TABLE = 4'd1;
  localparam logic [3:0] ERR_EMPTY    = 4'd2;
  localparam logic [3:0] ERR_TOKEN    = 4'd3;
  localparam logic [3:0] ERR_BRACKET  = 4'd4;
  localparam logic [3:0] ERR_OPERAND  = 4'd5;
  localparam logic [3:0] ERR_DIV0     = 4'd6;
  localparam logic [3:0] ERR_OPCODE   = 4'd7;
  localparam logic [3:0] ERR_OVERFLOW = 4'd8;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] number_value;
    logic [7:0]         token_char;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         error_code;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [31:0]      den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

[hdl/iee_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on iee_pkg for the request and response types.
`default_nettype none
module iee_div
  import iee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          rem;
  logic [31:0]          den;
  logic [DIV_W-1:0]     quo;
  logic [32:0]          sh;
  logic [33:0]          diff;
  logic                 ge;

  assign sh   = {rem, quo[DIV_W-1]};
  assign diff = {1'b0, sh} - {2'b00, den};
  assign ge   = ~diff[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        den  <= req.den;
        quo  <= req.num;
      end else if (busy) begin
        rem <= ge ? diff[31:0] : sh[31:0];
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
`default_nettype wire

[hdl/infix_expression_evaluator.sv]
// Top level of the infix expression evaluator: token sequencer, stacks, ALU.
// Depends on iee_pkg and iee_div.
//
//   port group | direction | word / width
//   in_*       | in        | in_word_t: action, number_value, token_char
//   out_*      | out       | out_word_t: value, error_code
//   cfg_*      | in        | cfg_index 2 bits, cfg_data 16 bits, no read-back
//
// A number or left bracket token is handled in S_IDLE alone. An operator, right
// bracket or end token probes the operator stack in S_TOP, then S_CHK (S_TOP
// alone if it is empty or an error is set); a reduction runs S_POPB, S_POPA
// and S_MUL or S_DIV (bit-serial divider); end reads out via S_FINRD, S_FIN.
// Reset (rst, synchronous) empties the stacks and clears the status, out_valid and the operator table.
// in_ready is low while a token is in work; an end token waits while an earlier result is still not taken.
`default_nettype none
module infix_expression_evaluator
  import iee_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_word_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_TOP   = 10'b0000000010,
    S_CHK   = 10'b0000000100,
    S_POPB  = 10'b0000001000,
    S_POPA  = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_FINRD = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    M_RB  = 2'd0,
    M_OP  = 2'd1,
    M_END = 2'd2
  } mode_t;

  logic [15:0]        op_entry [OP_ENTRIES];
  logic signed [31:0] opnd_mem [STACK_DEPTH];
  logic [IDX_W-1:0]   opr_mem  [STACK_DEPTH];

  state_t             state, state_next;
  mode_t              mode, mode_next;
  logic [CNT_W-1:0]   opnd_cnt, opnd_cnt_next;
  logic [CNT_W-1:0]   opr_cnt, opr_cnt_next;
  logic [3:0]         err, err_next;
  logic               token_seen, token_seen_next;
  logic [IDX_W-1:0]   cur_idx, cur_idx_next;
  logic [3:0]         cur_prio, cur_prio_next;
  logic               cur_left, cur_left_next;
  logic [2:0]         opc, opc_next;
  logic               neg, neg_next;
  logic signed [31:0] b, b_next;
  logic signed [63:0] prod;
  logic signed [31:0] opnd_rd;
  logic [IDX_W-1:0]   opr_rd;

  logic               opnd_we;
  logic [PTR_W-1:0]   opnd_waddr, opnd_raddr;
  logic signed [31:0] opnd_wdata;
  logic               opr_we;
  logic [PTR_W-1:0]   opr_waddr, opr_raddr;
  logic [IDX_W-1:0]   opr_wdata;
  logic               mul_load;
  logic               out_load;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               tbl_empty;
  logic               match_found;
  logic [ENT_W-1:0]   match_idx;
  logic [3:0]         err_in;
  logic [15:0]        top_entry;
  logic [15:0]        red_entry;
  logic [32:0]        sum;
  logic signed [63:0] mul_sh;
  logic [31:0]        mag_a, mag_b;
  logic [DIV_W-1:0]   qn;
  logic               q_ok;

  iee_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  function automatic logic [3:0] first_err(input logic [3:0] cur, input logic [3:0] code);
    first_err = (cur == ERR_OK) ? code : cur;
  endfunction

  always_comb begin
    tbl_empty   = 1'b1;
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = 0; i < OP_ENTRIES; i++) begin
      if (op_entry[i][7:0] != 8'd0) begin
        tbl_empty = 1'b0;
      end
      if (!match_found && op_entry[i][7:0] != 8'd0 &&
          op_entry[i][7:0] == in_data.token_char) begin
        match_found = 1'b1;
        match_idx   = ENT_W'(i);
      end
    end
  end

  assign err_in    = (err == ERR_OK && tbl_empty) ? ERR_NO_TABLE : err;
  assign top_entry = op_entry[opr_rd[ENT_W-1:0]];
  assign red_entry = top_entry;
  assign in_ready  = (state == S_IDLE);
  assign mag_b     = b[31] ? 32'(-b) : 32'(b);
  assign mul_sh    = prod >>> FRAC_W;

  always_comb begin
    state_next      = state;
    mode_next       = mode;
    opnd_cnt_next   = opnd_cnt;
    opr_cnt_next    = opr_cnt;
    err_next        = err;
    token_seen_next = token_seen;
    cur_idx_next    = cur_idx;
    cur_prio_next   = cur_prio;
    cur_left_next   = cur_left;
    opc_next        = opc;
    neg_next        = neg;
    b_next          = b;
    opnd_we         = 1'b0;
    opnd_waddr      = opnd_cnt[PTR_W-1:0];
    opnd_wdata      = in_data.number_value;
    opnd_raddr      = PTR_W'(opnd_cnt - 1'b1);
    opr_we          = 1'b0;
    opr_waddr       = opr_cnt[PTR_W-1:0];
    opr_wdata       = cur_idx;
    opr_raddr       = PTR_W'(opr_cnt - 1'b1);
    mul_load        = 1'b0;
    out_load        = 1'b0;
    div_req.start   = 1'b0;
    div_req.num     = '0;
    div_req.den     = mag_b;
    sum             = '0;
    mag_a           = '0;
    qn              = '0;
    q_ok            = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          err_next = err_in;
          case (in_data.action)
            ACT_NUMBER: begin
              token_seen_next = 1'b1;
              if (err_in == ERR_OK) begin
                if (opnd_cnt >= CNT_W'(STACK_DEPTH)) begin
                  err_next = ERR_OVERFLOW;
                end else begin
                  opnd_we       = 1'b1;
                  opnd_cnt_next = opnd_cnt + 1'b1;
                end
              end
            end
            ACT_SYMBOL: begin
              token_seen_next = 1'b1;
              if (err_in == ERR_OK) begin
                if (in_data.token_char == CH_LB) begin
                  if (opr_cnt >= CNT_W'(STACK_DEPTH)) begin
                    err_next = ERR_OVERFLOW;
                  end else begin
                    opr_we       = 1'b1;
                    opr_wdata    = LB_MARK;
                    opr_cnt_next = opr_cnt + 1'b1;
                  end
                end else if (in_data.token_char == CH_RB) begin
                  mode_next  = M_RB;
                  state_next = S_TOP;
                end else if (!match_found) begin
                  err_next = ERR_TOKEN;
                end else begin
                  cur_idx_next  = IDX_W'(match_idx);
                  cur_prio_next = op_entry[match_idx][14:11];
                  cur_left_next = op_entry[match_idx][15];
                  mode_next     = M_OP;
                  state_next    = S_TOP;
                end
              end
            end
            ACT_END: begin
              if (!token_seen) begin
                err_next = first_err(err_in, ERR_EMPTY);
              end
              mode_next  = M_END;
              state_next = S_TOP;
            end
            default: begin
              err_next = first_err(err_in, ERR_TOKEN);
            end
          endcase
        end
      end

      S_TOP: begin
        if (err != ERR_OK) begin
          state_next = (mode == M_END) ? S_FINRD : S_IDLE;
        end else if (opr_cnt == '0) begin
          case (mode)
            M_RB: begin
              err_next   = ERR_BRACKET;
              state_next = S_IDLE;
            end
            M_OP: begin
              opr_we       = 1'b1;
              opr_cnt_next = opr_cnt + 1'b1;
              state_next   = S_IDLE;
            end
            default: state_next = S_FINRD;
          endcase
        end else begin
          state_next = S_CHK;
        end
      end

      S_CHK: begin
        if (opr_rd == LB_MARK) begin
          case (mode)
            M_RB: begin
              opr_cnt_next = opr_cnt - 1'b1;
              state_next   = S_IDLE;
            end
            M_OP: begin
              if (opr_cnt >= CNT_W'(STACK_DEPTH)) begin
                err_next = ERR_OVERFLOW;
              end else begin
                opr_we       = 1'b1;
                opr_cnt_next = opr_cnt + 1'b1;
              end
              state_next = S_IDLE;
            end
            default: begin
              err_next   = ERR_BRACKET;
              state_next = S_FINRD;
            end
          endcase
        end else if (mode == M_OP && !(top_entry[14:11] > cur_prio ||
                     (top_entry[14:11] == cur_prio && cur_left))) begin
          if (opr_cnt >= CNT_W'(STACK_DEPTH)) begin
            err_next = ERR_OVERFLOW;
          end else begin
            opr_we       = 1'b1;
            opr_cnt_next = opr_cnt + 1'b1;
          end
          state_next = S_IDLE;
        end else begin
          opr_cnt_next = opr_cnt - 1'b1;
          opc_next     = red_entry[10:8];
          if (opnd_cnt < CNT_W'(2)) begin
            err_next   = ERR_OPERAND;
            state_next = S_TOP;
          end else begin
            opnd_cnt_next = opnd_cnt - 1'b1;
            state_next    = S_POPB;
          end
        end
      end

      S_POPB: begin
        b_next        = opnd_rd;
        opnd_cnt_next = opnd_cnt - 1'b1;
        state_next    = S_POPA;
      end

      S_POPA: begin
        state_next = S_TOP;
        case (opc)
          OPC_ADD, OPC_SUB: begin
            sum = (opc == OPC_ADD) ? 33'({opnd_rd[31], opnd_rd} + {b[31], b})
                                   : 33'({opnd_rd[31], opnd_rd} - {b[31], b});
            if (sum[32] != sum[31]) begin
              err_next = ERR_OVERFLOW;
            end else begin
              opnd_we       = 1'b1;
              opnd_wdata    = sum[31:0];
              opnd_cnt_next = opnd_cnt + 1'b1;
            end
          end
          OPC_MUL: begin
            mul_load   = 1'b1;
            state_next = S_MUL;
          end
          OPC_DIV: begin
            if (b == 32'sd0) begin
              err_next = ERR_DIV0;
            end else begin
              mag_a         = opnd_rd[31] ? 32'(-opnd_rd) : 32'(opnd_rd);
              div_req.start = 1'b1;
              div_req.num   = {mag_a, {FRAC_W{1'b0}}};
              neg_next      = opnd_rd[31] ^ b[31];
              state_next    = S_DIV;
            end
          end
          default: err_next = ERR_OPCODE;
        endcase
      end

      S_MUL: begin
        state_next = S_TOP;
        if (mul_sh[63:31] != {33{1'b0}} && mul_sh[63:31] != {33{1'b1}}) begin
          err_next = ERR_OVERFLOW;
        end else begin
          opnd_we       = 1'b1;
          opnd_wdata    = mul_sh[31:0];
          opnd_cnt_next = opnd_cnt + 1'b1;
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_TOP;
          qn         = neg ? DIV_W'(-div_rsp.quo) : div_rsp.quo;
          q_ok       = neg ? (div_rsp.quo <= DIV_W'(64'h8000_0000))
                           : (div_rsp.quo <  DIV_W'(64'h8000_0000));
          if (!q_ok) begin
            err_next = ERR_OVERFLOW;
          end else begin
            opnd_we       = 1'b1;
            opnd_wdata    = qn[31:0];
            opnd_cnt_next = opnd_cnt + 1'b1;
          end
        end
      end

      S_FINRD: begin
        opnd_raddr = '0;
        if (err == ERR_OK && opnd_cnt != CNT_W'(1)) begin
          err_next = ERR_OPERAND;
        end
        state_next = S_FIN;
      end

      S_FIN: begin
        opnd_raddr = '0;
        if (!out_valid || out_ready) begin
          out_load        = 1'b1;
          opnd_cnt_next   = '0;
          opr_cnt_next    = '0;
          err_next        = ERR_OK;
          token_seen_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= M_RB;
      opnd_cnt   <= '0;
      opr_cnt    <= '0;
      err        <= ERR_OK;
      token_seen <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < OP_ENTRIES; i++) begin
        op_entry[i] <= '0;
      end
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      opnd_cnt   <= opnd_cnt_next;
      opr_cnt    <= opr_cnt_next;
      err        <= err_next;
      token_seen <= token_seen_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && 32'(cfg_index) < OP_ENTRIES) begin
        op_entry[ENT_W'(cfg_index)] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_idx  <= cur_idx_next;
    cur_prio <= cur_prio_next;
    cur_left <= cur_left_next;
    opc      <= opc_next;
    neg      <= neg_next;
    b        <= b_next;
    if (mul_load) begin
      prod <= 64'(opnd_rd) * 64'(b);
    end
    if (out_load) begin
      out_data.value      <= (err == ERR_OK) ? opnd_rd : 32'sd0;
      out_data.error_code <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (opnd_we) begin
      opnd_mem[opnd_waddr] <= opnd_wdata;
    end
    opnd_rd <= opnd_mem[opnd_raddr];
    if (opr_we) begin
      opr_mem[opr_waddr] <= opr_wdata;
    end
    opr_rd <= opr_mem[opr_raddr];
  end

endmodule
`default_nettype wire
